@@ rtl/hlpt_pkg.sv @@
// Package for the hashed LRU page tag table: operation, status and slot-kind codes,
// hash constants, slot entry layout and state machine types.
// No dependencies.
package hlpt_pkg;

   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int HANDLE_W = 64;
   localparam int PAGE_W   = 52;
   localparam int FRAME_W  = 64;
   localparam int LIVE_W   = 11;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_EVICT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_LIVE  = 2'd1;
   localparam logic [1:0] KIND_TOMB  = 2'd2;

   localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

   typedef struct packed {
      logic [1:0]          kind;
      logic [HANDLE_W-1:0] handle;
      logic [PAGE_W-1:0]   page;
      logic [FRAME_W-1:0]  frame;
   } slot_entry_type;

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_MUL,
      HS_MOD,
      HS_DONE
   } hash_state_type;

   typedef enum logic [3:0] {
      TS_SWEEP,
      TS_IDLE,
      TS_HASH,
      TS_PROBE,
      TS_EVICT,
      TS_UNL_NEWER,
      TS_UNL_OLDER,
      TS_PUSH_SELF,
      TS_PUSH_PREV,
      TS_FINISH
   } tbl_state_type;

endpackage

@@ rtl/hlpt_hash.sv @@
// Key hash unit: 64-bit mix with two sequential 64x64 low-half multiplies on a
// shared 32x32 multiplier, then a 4-bit-per-cycle reduction modulo TABLE_SLOTS.
// Depends on hlpt_pkg.
module hlpt_hash
   import hlpt_pkg::*;
#(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [HANDLE_W-1:0]           handle,
   input  logic [PAGE_W-1:0]             page,
   output logic                          done,
   output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int LNK_W = $clog2(TABLE_SLOTS + 1);
   localparam int RW    = LNK_W + 4;
   localparam logic [RW-1:0] SLOTS_R = RW'(TABLE_SLOTS);

   hash_state_type   state_ff, state_in;
   logic [63:0]      v_ff, v_in;
   logic [63:0]      acc_ff, acc_in;
   logic [1:0]       step_ff, step_in;
   logic             round_ff, round_in;
   logic [3:0]       dig_ff, dig_in;
   logic [IDX_W-1:0] rem_ff, rem_in;

   logic [63:0] mix_x;
   logic [63:0] mul_b;
   logic [31:0] op_a, op_b;
   logic [63:0] prod;
   logic [63:0] acc_sum;
   logic [RW-1:0] red;

   always_comb begin
      mix_x   = handle ^ (64'(page) + MIX_GOLDEN + (handle << 6) + (handle >> 2));
      mul_b   = round_ff ? MIX_MUL_B : MIX_MUL_A;
      op_a    = (step_ff == 2'd1) ? v_ff[63:32] : v_ff[31:0];
      op_b    = (step_ff == 2'd2) ? mul_b[63:32] : mul_b[31:0];
      prod    = 64'(op_a) * 64'(op_b);
      acc_sum = (step_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
      // remainder step: value stays below 16 * TABLE_SLOTS
      red = (RW'(rem_ff) << 4) | RW'(v_ff[63:60]);
      for (int k = 3; k >= 0; k--) begin
         if (red >= (SLOTS_R << k)) begin
            red = red - (SLOTS_R << k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         HS_IDLE: if (start) state_in = HS_MUL;
         HS_MUL:  if (step_ff == 2'd2 && round_ff) state_in = HS_MOD;
         HS_MOD:  if (dig_ff == 4'd15) state_in = HS_DONE;
         HS_DONE: state_in = HS_IDLE;
         default: state_in = HS_IDLE;
      endcase
   end

   always_comb begin
      v_in     = v_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      round_in = round_ff;
      dig_in   = dig_ff;
      rem_in   = rem_ff;
      done     = 1'b0;
      slot     = rem_ff;
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               v_in     = mix_x ^ (mix_x >> 30);
               step_in  = 2'd0;
               round_in = 1'b0;
            end
         end
         HS_MUL: begin
            acc_in = acc_sum;
            if (step_ff == 2'd2) begin
               step_in = 2'd0;
               if (!round_ff) begin
                  v_in     = acc_sum ^ (acc_sum >> 27);
                  round_in = 1'b1;
               end else begin
                  v_in   = acc_sum ^ (acc_sum >> 31);
                  dig_in = 4'd0;
                  rem_in = '0;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         HS_MOD: begin
            rem_in = IDX_W'(red);
            v_in   = v_ff << 4;
            dig_in = dig_ff + 4'd1;
         end
         HS_DONE: done = 1'b1;
         default: done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      v_ff     <= v_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
      round_ff <= round_in;
      dig_ff   <= dig_in;
      rem_ff   <= rem_in;
   end

endmodule

@@ rtl/hashed_lru_page_tag_table_top.sv @@
// Hashed LRU page tag table: one item at a time. Each item passes through hashing (mix at
// the accepting edge, six multiply steps, 16 remainder steps, a done strobe), a probe step
// per slot probed, up to four link-list writes and the output register; clear sweeps all
// TABLE_SLOTS slots. Evict oldest on a non-empty list runs TS_EVICT, TS_UNL_NEWER and
// TS_UNL_OLDER before TS_FINISH registers its result. A new item is taken only after the
// last response is registered. Synchronous reset sweeps the slot memory, taking no req transfer.
module hashed_lru_page_tag_table_top
   import hlpt_pkg::*;
#(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [183:0] req_tdata,   // object_handle, page_number, new_frame, zero pad
   input  logic [2:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // frame_address, victim_handle, victim_page,
                                     // live_count, zero pad
   output logic [2:0]   rsp_tuser    // status
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int LNK_W = $clog2(TABLE_SLOTS + 1);
   localparam int LW    = LNK_W + 3;
   localparam logic [LNK_W-1:0] NULL_SLOT = LNK_W'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [LW-1:0]    LOAD_LIM  = LW'(TABLE_SLOTS * 3);

   // storage
   slot_entry_type   slot_mem  [TABLE_SLOTS];
   logic [LNK_W-1:0] older_mem [TABLE_SLOTS];
   logic [LNK_W-1:0] newer_mem [TABLE_SLOTS];

   tbl_state_type       state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [HANDLE_W-1:0] key_h_ff, key_h_in;
   logic [PAGE_W-1:0]   key_p_ff, key_p_in;
   logic [FRAME_W-1:0]  nf_ff, nf_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [LNK_W-1:0]    n_ff, n_in;
   logic                tomb_ok_ff, tomb_ok_in;
   logic [IDX_W-1:0]    tomb_ff, tomb_in;
   logic [IDX_W-1:0]    s_ff, s_in;
   logic                push_ff, push_in;
   logic                sweep_rsp_ff, sweep_rsp_in;
   logic [IDX_W-1:0]    sw_ff, sw_in;
   logic [LNK_W-1:0]    newest_ff, newest_in;
   logic [LNK_W-1:0]    oldest_ff, oldest_in;
   logic [LNK_W-1:0]    live_ff, live_in;
   logic [LNK_W-1:0]    tombs_ff, tombs_in;
   logic [LNK_W-1:0]    peak_ff, peak_in;
   logic [31:0]         hits_ff, hits_in;
   logic [31:0]         misses_ff, misses_in;
   logic [31:0]         inserts_ff, inserts_in;
   logic [31:0]         evicts_ff, evicts_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FRAME_W-1:0]  res_frame_ff, res_frame_in;
   logic [HANDLE_W-1:0] res_vh_ff, res_vh_in;
   logic [PAGE_W-1:0]   res_vp_ff, res_vp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [191:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]          rsp_user_ff, rsp_user_in;
   slot_entry_type      slot_rd_ff;
   logic [LNK_W-1:0]    lnk_old_rd_ff, lnk_new_rd_ff;

   // memory controls
   logic             slot_re, slot_we;
   logic [IDX_W-1:0] slot_raddr, slot_waddr;
   slot_entry_type   slot_wdata;
   logic             lnk_re, lnk_we_old, lnk_we_new;
   logic [IDX_W-1:0] lnk_raddr, lnk_waddr;
   logic [LNK_W-1:0] lnk_wold, lnk_wnew;

   logic             hash_start, hash_done;
   logic [IDX_W-1:0] hash_slot;

   logic             accept, out_free, key_match, rule_ok, at_bound;
   logic             first_tomb_ok, miss_end, tgt_is_tomb;
   logic [IDX_W-1:0] idx_next, first_tomb, target;
   logic [LNK_W-1:0] live_inc;
   logic [LW-1:0]    load_sum;

   hlpt_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .handle (req_tdata[63:0]),
      .page   (req_tdata[115:64]),
      .done   (hash_done),
      .slot   (hash_slot)
   );

   always_comb begin
      req_tready = (state_ff == TS_IDLE);
      accept     = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;
      idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      key_match  = (slot_rd_ff.handle == key_h_ff) && (slot_rd_ff.page == key_p_ff);
      at_bound   = (n_ff == LNK_W'(TABLE_SLOTS - 1));
      first_tomb_ok = tomb_ok_ff || (slot_rd_ff.kind == KIND_TOMB);
      first_tomb    = tomb_ok_ff ? tomb_ff : idx_ff;
      miss_end      = (slot_rd_ff.kind == KIND_EMPTY) || at_bound;
      if (slot_rd_ff.kind == KIND_EMPTY) begin
         target      = tomb_ok_ff ? tomb_ff : idx_ff;
         tgt_is_tomb = tomb_ok_ff;
      end else begin
         // probe bound reached without an empty slot
         target      = first_tomb_ok ? first_tomb : idx_next;
         tgt_is_tomb = first_tomb_ok;
      end
      load_sum = LW'(live_ff) + LW'(tombs_ff) + LW'(1);
      rule_ok  = (load_sum << 2) < LOAD_LIM;
      live_inc = live_ff + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TS_SWEEP: begin
            if (sw_ff == LAST_IDX) state_in = sweep_rsp_ff ? TS_FINISH : TS_IDLE;
         end
         TS_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  MODE_LOOKUP, MODE_GET, MODE_REMOVE: state_in = TS_HASH;
                  MODE_EVICT: state_in = (oldest_ff == NULL_SLOT) ? TS_FINISH : TS_EVICT;
                  MODE_CLEAR: state_in = TS_SWEEP;
                  default:    state_in = TS_FINISH;
               endcase
            end
         end
         TS_HASH: if (hash_done) state_in = TS_PROBE;
         TS_PROBE: begin
            if (slot_rd_ff.kind == KIND_LIVE && key_match) begin
               if (mode_ff == MODE_REMOVE || newest_ff != LNK_W'(idx_ff)) begin
                  state_in = TS_UNL_NEWER;
               end else begin
                  state_in = TS_FINISH;
               end
            end else if (miss_end) begin
               state_in = (mode_ff == MODE_GET && rule_ok) ? TS_PUSH_SELF : TS_FINISH;
            end
         end
         TS_EVICT:     state_in = TS_UNL_NEWER;
         TS_UNL_NEWER: state_in = TS_UNL_OLDER;
         TS_UNL_OLDER: state_in = push_ff ? TS_PUSH_SELF : TS_FINISH;
         TS_PUSH_SELF: state_in = TS_PUSH_PREV;
         TS_PUSH_PREV: state_in = TS_FINISH;
         TS_FINISH:    if (out_free) state_in = TS_IDLE;
         default:      state_in = TS_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in       = mode_ff;
      key_h_in      = key_h_ff;
      key_p_in      = key_p_ff;
      nf_in         = nf_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      tomb_ok_in    = tomb_ok_ff;
      tomb_in       = tomb_ff;
      s_in          = s_ff;
      push_in       = push_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      sw_in         = sw_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      live_in       = live_ff;
      tombs_in      = tombs_ff;
      peak_in       = peak_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      inserts_in    = inserts_ff;
      evicts_in     = evicts_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_vh_in     = res_vh_ff;
      res_vp_in     = res_vp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      hash_start    = 1'b0;
      slot_re       = 1'b0;
      slot_raddr    = idx_ff;
      slot_we       = 1'b0;
      slot_waddr    = idx_ff;
      slot_wdata    = slot_rd_ff;
      lnk_re        = 1'b0;
      lnk_raddr     = idx_ff;
      lnk_we_old    = 1'b0;
      lnk_we_new    = 1'b0;
      lnk_waddr     = s_ff;
      lnk_wold      = NULL_SLOT;
      lnk_wnew      = NULL_SLOT;
      unique case (state_ff)
         TS_SWEEP: begin
            slot_we    = 1'b1;
            slot_waddr = sw_ff;
            slot_wdata = '0;
            sw_in      = sw_ff + 1'b1;
            if (sw_ff == LAST_IDX) begin
               newest_in     = NULL_SLOT;
               oldest_in     = NULL_SLOT;
               live_in       = '0;
               tombs_in      = '0;
               res_status_in = ST_CLEARED;
            end
         end
         TS_IDLE: begin
            if (accept) begin
               mode_in       = req_tuser;
               key_h_in      = req_tdata[63:0];
               key_p_in      = req_tdata[115:64];
               nf_in         = req_tdata[179:116];
               res_status_in = ST_NOT_FOUND;
               res_frame_in  = '0;
               res_vh_in     = '0;
               res_vp_in     = '0;
               push_in       = 1'b0;
               tomb_ok_in    = 1'b0;
               unique case (req_tuser)
                  MODE_LOOKUP, MODE_GET, MODE_REMOVE: hash_start = 1'b1;
                  MODE_EVICT: begin
                     if (oldest_ff == NULL_SLOT) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        slot_re    = 1'b1;
                        slot_raddr = oldest_ff[IDX_W-1:0];
                        s_in       = oldest_ff[IDX_W-1:0];
                     end
                  end
                  MODE_CLEAR: begin
                     sw_in        = '0;
                     sweep_rsp_in = 1'b1;
                  end
                  default: res_status_in = ST_NOT_FOUND;
               endcase
            end
         end
         TS_HASH: begin
            if (hash_done) begin
               slot_re    = 1'b1;
               slot_raddr = hash_slot;
               idx_in     = hash_slot;
               n_in       = '0;
            end
         end
         TS_PROBE: begin
            if (slot_rd_ff.kind == KIND_LIVE && key_match) begin
               s_in         = idx_ff;
               res_frame_in = slot_rd_ff.frame;
               lnk_raddr    = idx_ff;
               if (mode_ff == MODE_REMOVE) begin
                  res_status_in   = ST_REMOVED;
                  slot_we         = 1'b1;
                  slot_waddr      = idx_ff;
                  slot_wdata.kind = KIND_TOMB;
                  live_in         = live_ff - 1'b1;
                  tombs_in        = tombs_ff + 1'b1;
                  evicts_in       = evicts_ff + 32'd1;
                  lnk_re          = 1'b1;
                  push_in         = 1'b0;
               end else begin
                  res_status_in = ST_HIT;
                  hits_in       = hits_ff + 32'd1;
                  if (newest_ff != LNK_W'(idx_ff)) begin
                     lnk_re  = 1'b1;
                     push_in = 1'b1;
                  end
               end
            end else if (miss_end) begin
               if (mode_ff == MODE_GET) begin
                  misses_in = misses_ff + 32'd1;
                  if (rule_ok) begin
                     slot_we    = 1'b1;
                     slot_waddr = target;
                     slot_wdata = '{kind: KIND_LIVE, handle: key_h_ff, page: key_p_ff,
                                    frame: nf_ff};
                     if (tgt_is_tomb) tombs_in = tombs_ff - 1'b1;
                     live_in       = live_inc;
                     inserts_in    = inserts_ff + 32'd1;
                     if (live_inc > peak_ff) peak_in = live_inc;
                     res_status_in = ST_INSERTED;
                     res_frame_in  = nf_ff;
                     s_in          = target;
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
            end else begin
               tomb_ok_in = first_tomb_ok;
               tomb_in    = first_tomb;
               idx_in     = idx_next;
               n_in       = n_ff + 1'b1;
               slot_re    = 1'b1;
               slot_raddr = idx_next;
            end
         end
         TS_EVICT: begin
            res_status_in   = ST_REMOVED;
            res_frame_in    = slot_rd_ff.frame;
            res_vh_in       = slot_rd_ff.handle;
            res_vp_in       = slot_rd_ff.page;
            slot_we         = 1'b1;
            slot_waddr      = s_ff;
            slot_wdata.kind = KIND_TOMB;
            live_in         = live_ff - 1'b1;
            tombs_in        = tombs_ff + 1'b1;
            evicts_in       = evicts_ff + 32'd1;
            lnk_re          = 1'b1;
            lnk_raddr       = s_ff;
            push_in         = 1'b0;
         end
         TS_UNL_NEWER: begin
            if (lnk_new_rd_ff != NULL_SLOT) begin
               lnk_we_old = 1'b1;
               lnk_waddr  = lnk_new_rd_ff[IDX_W-1:0];
               lnk_wold   = lnk_old_rd_ff;
            end else begin
               newest_in = lnk_old_rd_ff;
            end
         end
         TS_UNL_OLDER: begin
            if (lnk_old_rd_ff != NULL_SLOT) begin
               lnk_we_new = 1'b1;
               lnk_waddr  = lnk_old_rd_ff[IDX_W-1:0];
               lnk_wnew   = lnk_new_rd_ff;
            end else begin
               oldest_in = lnk_new_rd_ff;
            end
         end
         TS_PUSH_SELF: begin
            lnk_we_old = 1'b1;
            lnk_we_new = 1'b1;
            lnk_waddr  = s_ff;
            lnk_wold   = newest_ff;
            lnk_wnew   = NULL_SLOT;
         end
         TS_PUSH_PREV: begin
            if (newest_ff != NULL_SLOT) begin
               lnk_we_new = 1'b1;
               lnk_waddr  = newest_ff[IDX_W-1:0];
               lnk_wnew   = LNK_W'(s_ff);
            end else begin
               oldest_in = LNK_W'(s_ff);
            end
            newest_in = LNK_W'(s_ff);
         end
         TS_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {1'b0, LIVE_W'(live_ff), res_vp_ff, res_vh_ff, res_frame_ff};
               sweep_rsp_in = 1'b0;
            end
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_tready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_SWEEP;
         sw_ff        <= '0;
         sweep_rsp_ff <= 1'b0;
         newest_ff    <= NULL_SLOT;
         oldest_ff    <= NULL_SLOT;
         live_ff      <= '0;
         tombs_ff     <= '0;
         peak_ff      <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         inserts_ff   <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         sweep_rsp_ff <= sweep_rsp_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         live_ff      <= live_in;
         tombs_ff     <= tombs_in;
         peak_ff      <= peak_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         inserts_ff   <= inserts_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_h_ff      <= key_h_in;
      key_p_ff      <= key_p_in;
      nf_ff         <= nf_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      tomb_ok_ff    <= tomb_ok_in;
      tomb_ff       <= tomb_in;
      s_ff          <= s_in;
      push_ff       <= push_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_vh_ff     <= res_vh_in;
      res_vp_ff     <= res_vp_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   // recency link memory, one write enable per field
   always_ff @(posedge clock) begin
      if (lnk_we_old) begin
         older_mem[lnk_waddr] <= lnk_wold;
      end
      if (lnk_we_new) begin
         newer_mem[lnk_waddr] <= lnk_wnew;
      end
      if (lnk_re) begin
         lnk_old_rd_ff <= older_mem[lnk_raddr];
         lnk_new_rd_ff <= newer_mem[lnk_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // load rule keeps at least a quarter of the slots empty
   assert property (@(posedge clock) disable iff (reset)
      ((LW'(live_ff) + LW'(tombs_ff)) << 2) < LOAD_LIM)
      else $error("slot load above three quarters");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == TS_IDLE |->
         ((newest_ff == NULL_SLOT) == (oldest_ff == NULL_SLOT)) &&
         ((live_ff == '0) == (newest_ff == NULL_SLOT)))
      else $error("recency list ends disagree with live count");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != TS_IDLE)
      else $error("accepted transfer not taken into work");

endmodule
